// ----- rtl/adf_pkg.sv -----
// ----------------------------------------------------------------------------
// adf_pkg
// types, codes and helpers shared by the air data frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package adf_pkg;

  // frame parser phase
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_HEADER = 2'd1,
    PH_STATUS = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  // result kind codes
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_MASK_G1  = 3'd0;
  localparam logic [2:0] REG_MASK_G6  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT  = 3'd6;

  localparam int NUM_GROUPS = 6;

  // register reset values
  localparam logic [15:0] MASK_G1_RST = 16'h67FE;
  localparam logic [15:0] MASK_G2_RST = 16'h0686;
  localparam logic [15:0] MASK_G3_RST = 16'h3C7E;
  localparam logic [15:0] MASK_G4_RST = 16'h0000;
  localparam logic [15:0] MASK_G5_RST = 16'h0000;
  localparam logic [15:0] MASK_G6_RST = 16'h003E;
  localparam logic [15:0] TIMEOUT_RST = 16'd60;

  // framing bytes and header fields
  localparam logic [7:0] TERM_CR        = 8'h0D;
  localparam logic [2:0] STATUS_GROUP   = 3'd1;
  localparam logic [3:0] STAT_HDR_LABEL = 4'd15;
  localparam logic [7:0] START_MIN      = 8'h01;
  localparam logic [7:0] START_MAX      = 8'h06;

  // result tdata layout, lowest bit up
  localparam int TD_GROUP_LSB = 0;
  localparam int TD_LABEL_LSB = 3;
  localparam int TD_WORD_LSB  = 7;
  localparam int TD_FLAG_LSB  = 39;
  localparam int TD_TERM_BIT  = 42;
  localparam int TD_HEX_BIT   = 43;
  localparam int TD_TOUT_BIT  = 44;
  localparam int TDATA_W      = 48;

  typedef logic [NUM_GROUPS-1:0][15:0] mask_bank_t;

  // completed frame from the parser
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [2:0]  group;
    logic [3:0]  label;
    logic [31:0] word;
    logic [2:0]  hdr_flag;
    logic        term_ok;
    logic        hex_error;
  } frame_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  // ascii hex character to nibble, both cases
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.nib = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.nib = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/adf_frame_parser.sv -----
// ----------------------------------------------------------------------------
// adf_frame_parser
// start / header / character state machine, one byte per call
// ----------------------------------------------------------------------------
`default_nettype none

module adf_frame_parser #(
  parameter int DATA_CHARS   = 8,
  parameter int STATUS_CHARS = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 byte_en,
  input  wire [7:0]           rx_byte,
  input  adf_pkg::mask_bank_t masks,
  output adf_pkg::frame_t     frame
);

  localparam int CHAR_LIMIT = (DATA_CHARS > STATUS_CHARS) ? DATA_CHARS : STATUS_CHARS;
  localparam int CW         = $clog2(CHAR_LIMIT + 1);

  adf_pkg::phase_t phase, phase_next;
  logic [2:0]      cur_group;
  logic [3:0]      cur_label;
  logic [2:0]      cur_flag;
  logic [CW-1:0]   char_count;
  logic [31:0]     accum_word;
  logic            bad_char;

  logic            is_start;
  logic            hdr_mark;
  logic [3:0]      hdr_label;
  logic            is_status_hdr;
  logic            label_en;
  logic            do_start;
  logic            do_header;
  logic            do_collect;
  logic            do_emit;
  adf_pkg::hex_t   hx;
  logic [2:0]      grp_idx;

  assign is_start      = (rx_byte >= adf_pkg::START_MIN) && (rx_byte <= adf_pkg::START_MAX);
  assign hdr_mark      = rx_byte[7];
  assign hdr_label     = rx_byte[3:0];
  assign is_status_hdr = (cur_group == adf_pkg::STATUS_GROUP) &&
                         (hdr_label == adf_pkg::STAT_HDR_LABEL);
  assign grp_idx       = cur_group - 3'd1;
  assign label_en      = (cur_group >= 3'd1) && (cur_group <= 3'(adf_pkg::NUM_GROUPS)) &&
                         masks[grp_idx][hdr_label];
  assign hx            = adf_pkg::hex_decode(rx_byte);

  // next phase
  always_comb begin
    phase_next = phase;
    if (byte_en) begin
      case (phase)
        adf_pkg::PH_START: begin
          if (is_start) phase_next = adf_pkg::PH_HEADER;
        end
        adf_pkg::PH_HEADER: begin
          if (!hdr_mark)          phase_next = adf_pkg::PH_START;
          else if (is_status_hdr) phase_next = adf_pkg::PH_STATUS;
          else if (label_en)      phase_next = adf_pkg::PH_DATA;
          else                    phase_next = adf_pkg::PH_START;
        end
        adf_pkg::PH_STATUS: begin
          if (char_count >= CW'(STATUS_CHARS)) phase_next = adf_pkg::PH_START;
        end
        adf_pkg::PH_DATA: begin
          if (char_count >= CW'(DATA_CHARS)) phase_next = adf_pkg::PH_START;
        end
        default: phase_next = adf_pkg::PH_START;
      endcase
    end
  end

  // actions of the current phase
  always_comb begin
    do_start   = 1'b0;
    do_header  = 1'b0;
    do_collect = 1'b0;
    do_emit    = 1'b0;
    if (byte_en) begin
      case (phase)
        adf_pkg::PH_START:  do_start  = is_start;
        adf_pkg::PH_HEADER: do_header = hdr_mark;
        adf_pkg::PH_STATUS: begin
          do_collect = (char_count <  CW'(STATUS_CHARS));
          do_emit    = (char_count >= CW'(STATUS_CHARS));
        end
        adf_pkg::PH_DATA: begin
          do_collect = (char_count <  CW'(DATA_CHARS));
          do_emit    = (char_count >= CW'(DATA_CHARS));
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    frame           = '0;
    frame.valid     = do_emit;
    frame.kind      = (phase == adf_pkg::PH_STATUS) ? adf_pkg::KIND_STATUS
                                                    : adf_pkg::KIND_DATA;
    frame.group     = cur_group;
    frame.label     = cur_label;
    frame.word      = (phase == adf_pkg::PH_STATUS) ? {16'd0, accum_word[15:0]} : accum_word;
    frame.hdr_flag  = cur_flag;
    frame.term_ok   = (rx_byte == adf_pkg::TERM_CR);
    frame.hex_error = bad_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= adf_pkg::PH_START;
      cur_group  <= '0;
      cur_label  <= '0;
      cur_flag   <= '0;
      char_count <= '0;
      accum_word <= '0;
      bad_char   <= 1'b0;
    end else begin
      phase <= phase_next;
      if (do_start) begin
        cur_group  <= rx_byte[2:0];
        char_count <= '0;
        accum_word <= '0;
        bad_char   <= 1'b0;
      end
      if (do_header) begin
        cur_label <= hdr_label;
        cur_flag  <= rx_byte[6:4];
      end
      if (do_collect) begin
        accum_word <= {accum_word[27:0], hx.nib};
        char_count <= char_count + CW'(1);
        if (!hx.ok) bad_char <= 1'b1;
      end
      if (do_emit) char_count <= '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/adf_timeout.sv -----
// ----------------------------------------------------------------------------
// adf_timeout
// idle tick counter and timeout flag
// ----------------------------------------------------------------------------
`default_nettype none

module adf_timeout (
  input  wire        clk,
  input  wire        rst,
  input  wire        tick,
  input  wire        data_done,
  input  wire [15:0] limit,
  output logic       flag,
  output logic       flag_next
);

  logic [15:0] idle_ticks;
  logic [15:0] idle_ticks_next;

  always_comb begin
    idle_ticks_next = idle_ticks;
    flag_next       = flag;
    if (tick) begin
      if (idle_ticks != 16'hFFFF) idle_ticks_next = idle_ticks + 16'd1;
      flag_next = (idle_ticks_next >= limit);
    end else if (data_done) begin
      idle_ticks_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= '0;
      flag       <= 1'b0;
    end else begin
      idle_ticks <= idle_ticks_next;
      flag       <= flag_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/air_data_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// air_data_frame_deframer
// serial air data deframer: start byte, header, hex characters, terminator
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  -----------------------------------------
//  s_*       in   s_tvalid/s_tready  tuser = op, tdata = rx_byte
//  m_*       out  m_tvalid/m_tready  tuser = kind, tdata = frame fields
//  cfg_*     in   cfg_valid/ready    cfg_index = register, cfg_data = value
//
//  one item is taken per cycle while the output is free; its result, if any,
//  sits in the output register from the next cycle on
//  the output register is the only stage: a new item is taken whenever it is
//  empty or being drained in the same cycle
//  reset is synchronous and clears the parser phase, the tick counter, the
//  output valid and the registers to their default values; no clearing pass
//  the config port is always ready; the user must write it only while the
//  block is idle, which the block itself does not enforce
`default_nettype none

module air_data_frame_deframer #(
  parameter int DATA_CHARS   = 8,
  parameter int STATUS_CHARS = 4
) (
  input  wire                          clk,
  input  wire                          rst,
  // input stream
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [7:0]                   s_tdata,   // [7:0] rx_byte
  input  wire                          s_tuser,   // [0] op
  // result stream
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [adf_pkg::TDATA_W-1:0]  m_tdata,   // [2:0] group, [6:3] label,
                                                  // [38:7] word, [41:39] hdr_flag,
                                                  // [42] term_ok, [43] hex_error,
                                                  // [44] timed_out, [47:45] zero
  output logic [1:0]                   m_tuser,   // [1:0] kind
  // configuration writes
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [2:0]                   cfg_index,
  input  wire  [15:0]                  cfg_data
);

  // register file
  adf_pkg::mask_bank_t masks;
  logic [15:0]         timeout_ticks;

  logic                s_fire;
  logic                byte_en;
  logic                tick_en;
  adf_pkg::frame_t     frame;
  logic                tout_flag;
  logic                tout_flag_next;
  logic                res_valid;
  logic [1:0]          res_kind;
  logic [adf_pkg::TDATA_W-1:0] res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      masks[0]      <= adf_pkg::MASK_G1_RST;
      masks[1]      <= adf_pkg::MASK_G2_RST;
      masks[2]      <= adf_pkg::MASK_G3_RST;
      masks[3]      <= adf_pkg::MASK_G4_RST;
      masks[4]      <= adf_pkg::MASK_G5_RST;
      masks[5]      <= adf_pkg::MASK_G6_RST;
      timeout_ticks <= adf_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // mask registers start at index zero
      if (cfg_index <= adf_pkg::REG_MASK_G6) begin
        masks[cfg_index] <= cfg_data;
      end else if (cfg_index == adf_pkg::REG_TIMEOUT) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

  // take a new item whenever the result slot frees up this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign byte_en  = s_fire && (s_tuser == adf_pkg::OP_BYTE);
  assign tick_en  = s_fire && (s_tuser == adf_pkg::OP_TICK);

  adf_frame_parser #(
    .DATA_CHARS   (DATA_CHARS),
    .STATUS_CHARS (STATUS_CHARS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .byte_en (byte_en),
    .rx_byte (s_tdata),
    .masks   (masks),
    .frame   (frame)
  );

  // only a completed data frame restarts the idle count
  adf_timeout u_timeout (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick_en),
    .data_done (frame.valid && (frame.kind == adf_pkg::KIND_DATA)),
    .limit     (timeout_ticks),
    .flag      (tout_flag),
    .flag_next (tout_flag_next)
  );

  // result assembly: tick report or completed frame
  always_comb begin
    res_valid = tick_en || frame.valid;
    res_kind  = adf_pkg::KIND_TICK;
    res_data  = '0;
    if (tick_en) begin
      res_data[adf_pkg::TD_TOUT_BIT] = tout_flag_next;
    end else begin
      res_kind = frame.kind;
      res_data[adf_pkg::TD_GROUP_LSB +: 3] = frame.group;
      res_data[adf_pkg::TD_LABEL_LSB +: 4] = frame.label;
      res_data[adf_pkg::TD_WORD_LSB  +: 32] = frame.word;
      res_data[adf_pkg::TD_FLAG_LSB  +: 3] = frame.hdr_flag;
      res_data[adf_pkg::TD_TERM_BIT]       = frame.term_ok;
      res_data[adf_pkg::TD_HEX_BIT]        = frame.hex_error;
      // a frame reports the flag as it stands
      res_data[adf_pkg::TD_TOUT_BIT]       = tout_flag;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && res_valid) begin
      m_tdata <= res_data;
      m_tuser <= res_kind;
    end
  end

  // every accepted tick yields a tick report in the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == adf_pkg::OP_TICK)
      |=> (m_tvalid && m_tuser == adf_pkg::KIND_TICK))
    else $error("tick item without tick report");

  // a tick report carries nothing but the timeout flag
  a_tick_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == adf_pkg::KIND_TICK) |-> (m_tdata[adf_pkg::TD_HEX_BIT:0] == '0))
    else $error("tick report with frame fields set");

  // a status word keeps only 16 bits, and status frames come from group 1
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == adf_pkg::KIND_STATUS)
      |-> (m_tdata[adf_pkg::TD_WORD_LSB + 16 +: 16] == 16'd0 &&
           m_tdata[adf_pkg::TD_GROUP_LSB +: 3] == adf_pkg::STATUS_GROUP))
    else $error("status result malformed");

  // a byte item never produces a result unless a frame completes
  a_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == adf_pkg::OP_BYTE && !frame.valid) |=> !m_tvalid)
    else $error("result without completed frame");

endmodule

`default_nettype wire

// ----- dv/tb_air_data_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// tb_air_data_frame_deframer
// self-checking bench: serial bytes and ticks in, frame and tick reports out
// ----------------------------------------------------------------------------
// a directed opening covers ignored start bytes, a status frame, dropped
// headers and a data frame with a non-hex character and a bad terminator.
// random phases then send mostly well-formed frames with random content,
// mixed with ticks, noise and cut-off frames, under several register settings.
// a scoreboard mirrors the deframer state and checks every result in order
// ----------------------------------------------------------------------------

module tb_air_data_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import adf_pkg::*;

  localparam int DATA_LEN    = 8;
  localparam int STATUS_LEN  = 4;
  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS = 148;

  // one result item as the deframer reports it
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  group;
    logic [3:0]  label;
    logic [31:0] word;
    logic [2:0]  hdr_flag;
    logic        term_ok;
    logic        hex_error;
    logic        timed_out;
  } frame_res_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirror of the parser, tick counter and registers
  // --------------------------------------------------------------------------
  class frame_tracker;
    logic [15:0] label_mask [NUM_GROUPS];
    logic [15:0] timeout_limit;
    phase_t      ph;
    logic [2:0]  grp;
    logic [3:0]  lbl;
    logic [2:0]  flg;
    int unsigned nchars;
    logic [31:0] acc;
    logic        bad;
    logic [15:0] idle_ticks;
    logic        tout;
    frame_res_t  pending_frames [$];
    int          mismatches;
    int          seen [3];

    function new();
      label_mask[0] = MASK_G1_RST;
      label_mask[1] = MASK_G2_RST;
      label_mask[2] = MASK_G3_RST;
      label_mask[3] = MASK_G4_RST;
      label_mask[4] = MASK_G5_RST;
      label_mask[5] = MASK_G6_RST;
      timeout_limit = TIMEOUT_RST;
      ph = PH_START;
      grp = '0;
      lbl = '0;
      flg = '0;
      nchars = 0;
      acc = '0;
      bad = 1'b0;
      idle_ticks = '0;
      tout = 1'b0;
      mismatches = 0;
      seen = '{0, 0, 0};
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      if (idx < REG_TIMEOUT) begin
        label_mask[idx] = val;
      end else if (idx == REG_TIMEOUT) begin
        timeout_limit = val;
      end
    endfunction

    // ascii hex digit to value, -1 if not a hex digit
    function int hex_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
    endfunction

    function void add_char(logic [7:0] c);
      int n;
      n = hex_value(c);
      if (n < 0) begin
        bad = 1'b1;
        n = 0;
      end
      acc = {acc[27:0], 4'(n)};
      nchars++;
    endfunction

    function void push_frame(logic [1:0] k, logic [7:0] term_byte, logic [31:0] w);
      frame_res_t f;
      f.kind = k;
      f.group = grp;
      f.label = lbl;
      f.word = w;
      f.hdr_flag = flg;
      f.term_ok = (term_byte == TERM_CR);
      f.hex_error = bad;
      f.timed_out = tout;
      pending_frames.push_back(f);
    endfunction

    // note one accepted input item and queue the result it causes, if any
    function void take_item(logic op, logic [7:0] c);
      frame_res_t f;
      if (op == OP_TICK) begin
        if (idle_ticks != 16'hFFFF) idle_ticks++;
        tout = (idle_ticks >= timeout_limit);
        f = '0;
        f.kind = KIND_TICK;
        f.timed_out = tout;
        pending_frames.push_back(f);
        return;
      end
      case (ph)
        PH_START: begin
          if (c >= START_MIN && c <= START_MAX) begin
            grp = c[2:0];
            nchars = 0;
            acc = '0;
            bad = 1'b0;
            ph = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (!c[7]) begin
            ph = PH_START;
          end else begin
            lbl = c[3:0];
            flg = c[6:4];
            if (grp == STATUS_GROUP && lbl == STAT_HDR_LABEL) begin
              ph = PH_STATUS;
            end else if (label_mask[int'(grp) - 1][lbl]) begin
              ph = PH_DATA;
            end else begin
              ph = PH_START;
            end
          end
        end
        PH_STATUS: begin
          if (nchars < STATUS_LEN) begin
            add_char(c);
          end else begin
            push_frame(KIND_STATUS, c, {16'h0, acc[15:0]});
            nchars = 0;
            ph = PH_START;
          end
        end
        default: begin
          if (nchars < DATA_LEN) begin
            add_char(c);
          end else begin
            push_frame(KIND_DATA, c, acc);
            idle_ticks = '0;
            nchars = 0;
            ph = PH_START;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one accepted result with the oldest expected one
    function void check_frame(logic [1:0] kind, logic [TDATA_W-1:0] td);
      frame_res_t want;
      if (pending_frames.size() == 0) begin
        $error("result with nothing expected: kind 0x%0h tdata 0x%0h", kind, td);
        mismatches++;
        return;
      end
      want = pending_frames.pop_front();
      if (want.kind <= KIND_TICK) seen[want.kind]++;
      compare_field("kind", want.kind, kind);
      compare_field("group", want.group, td[TD_GROUP_LSB +: 3]);
      compare_field("label", want.label, td[TD_LABEL_LSB +: 4]);
      compare_field("word", want.word, td[TD_WORD_LSB +: 32]);
      compare_field("hdr_flag", want.hdr_flag, td[TD_FLAG_LSB +: 3]);
      compare_field("term_ok", want.term_ok, td[TD_TERM_BIT]);
      compare_field("hex_error", want.hex_error, td[TD_HEX_BIT]);
      compare_field("timed_out", want.timed_out, td[TD_TOUT_BIT]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block signals; every input known from time zero
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;    // [7:0] rx_byte
  logic               s_tuser = 1'b0;  // [0] op
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;         // [2:0] group, [6:3] label, [38:7] word,
                                       // [41:39] hdr_flag, [42] term_ok,
                                       // [43] hex_error, [44] timed_out
  logic [1:0]         m_tuser;         // [1:0] kind
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  frame_tracker sb = new();

  int    useful_items = 0;  // items that are not plain noise
  int    pushes = 0;
  int    drains = 0;
  bit    steady_send = 1'b0;
  bit    steady_recv = 1'b0;
  int    quiet = 0;
  string hex_chars = "0123456789abcdefABCDEF";

  always #5 clk = ~clk;

  air_data_frame_deframer #(
    .DATA_CHARS  (DATA_LEN),
    .STATUS_CHARS(STATUS_LEN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // result side: random stall per item, with runs of no stall
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (drains % 32 == 0) steady_recv = ($urandom_range(0, 2) == 0);
      drains++;
      stall = steady_recv ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_frame(m_tuser, m_tdata);
  end

  // watchdog: a long run of cycles without any handshake ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // offer one item after a random gap and note it once accepted
  task automatic push_item(input logic op, input logic [7:0] b);
    int gap;
    if (pushes % 32 == 0) steady_send = ($urandom_range(0, 2) == 0);
    pushes++;
    gap = steady_send ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.take_item(op, b);
  endtask

  // one frame byte, now and then preceded by a tick
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 19) == 0) begin
      push_item(OP_TICK, 8'($urandom));
      useful_items++;
    end
    push_item(OP_BYTE, b);
    useful_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(OP_BYTE, s[i]);
  endtask

  // random frame: mostly well formed, sometimes no marker or cut short
  task automatic send_frame();
    logic [2:0]  g;
    logic [3:0]  l;
    logic [15:0] m;
    logic        is_status;
    int          nch;
    logic [7:0]  c;
    g = 3'($urandom_range(1, 6));
    m = sb.label_mask[int'(g) - 1];
    is_status = (g == STATUS_GROUP) && ($urandom_range(0, 3) == 0);
    if (is_status) begin
      l = STAT_HDR_LABEL;
    end else if (m != 16'h0 && $urandom_range(0, 1) == 1) begin
      do l = 4'($urandom_range(0, 15)); while (!m[l]);
    end else begin
      l = 4'($urandom_range(0, 15));
    end
    nch = (g == STATUS_GROUP && l == STAT_HDR_LABEL) ? STATUS_LEN : DATA_LEN;
    send_byte({5'h0, g});
    send_byte({($urandom_range(0, 9) != 0), 3'($urandom_range(0, 7)), l});
    // cut-off frame: fewer characters and no terminator
    if ($urandom_range(0, 9) == 0) nch = $urandom_range(0, nch - 1);
    else nch = nch + 1;
    for (int i = 0; i < nch; i++) begin
      if (i == nch - 1 && nch > 1 && $urandom_range(0, 4) != 0) begin
        c = TERM_CR;
      end else if ($urandom_range(0, 7) != 0) begin
        c = hex_chars[$urandom_range(0, hex_chars.len() - 1)];
      end else begin
        c = 8'($urandom);
      end
      send_byte(c);
    end
  endtask

  task automatic run_random(input int n_items);
    int start_count;
    int r;
    start_count = useful_items;
    while (useful_items - start_count < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_item(OP_TICK, 8'($urandom));
        useful_items++;
      end else if (r < 16) begin
        push_item(OP_BYTE, 8'($urandom));  // noise between frames
      end else begin
        send_frame();
      end
    end
  endtask

  // let the block go idle: wait until all results are drained
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_frames.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, val);
  endtask

  task automatic load_settings(input logic [15:0] masks [NUM_GROUPS],
                               input logic [15:0] tmo);
    for (int g = 0; g < NUM_GROUPS; g++) write_reg(REG_MASK_G1 + 3'(g), masks[g]);
    write_reg(REG_TIMEOUT, tmo);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] masks [NUM_GROUPS];
    logic [15:0] tmo;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset register values
    push_item(OP_TICK, 8'hA5);
    push_item(OP_BYTE, 8'h00);           // not a start byte
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h07);           // just above the start range
    push_item(OP_BYTE, 8'h01);           // status frame, all flag bits set
    push_item(OP_BYTE, 8'hFF);
    send_text("fFAa");
    push_item(OP_BYTE, TERM_CR);
    push_item(OP_BYTE, 8'h02);           // header without marker is dropped
    push_item(OP_BYTE, 8'h05);
    push_item(OP_BYTE, 8'h04);           // label not enabled in group 4
    push_item(OP_BYTE, 8'h80);
    push_item(OP_BYTE, 8'h06);           // data frame with a non-hex character
    push_item(OP_BYTE, 8'h81);
    send_text("0g9A7bE1");
    push_item(OP_BYTE, 8'h0A);           // terminator other than CR
    push_item(OP_TICK, 8'h5A);
    settle();

    // random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      foreach (masks[g]) masks[g] = 16'($urandom);
      case (p)
        0: begin
          foreach (masks[g]) masks[g] = 16'hFFFF;
          tmo = 16'd1;
        end
        1: begin
          foreach (masks[g]) masks[g] = 16'h0000;
          tmo = 16'hFFFF;
        end
        2: tmo = 16'd0;                  // every tick reports a timeout
        3: tmo = 16'($urandom_range(2, 8));
        4: begin
          masks = '{MASK_G1_RST, MASK_G2_RST, MASK_G3_RST,
                    MASK_G4_RST, MASK_G5_RST, MASK_G6_RST};
          tmo = TIMEOUT_RST;
        end
        default: tmo = 16'($urandom_range(1, 16));
      endcase
      load_settings(masks, tmo);
      run_random(PHASE_ITEMS);
      settle();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d data frames, %0d status frames and %0d tick reports",
             sb.seen[KIND_DATA], sb.seen[KIND_STATUS], sb.seen[KIND_TICK]);
    $display("from %0d input items under seven register settings", pushes);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/adf_pkg.sv
rtl/adf_frame_parser.sv
rtl/adf_timeout.sv
rtl/air_data_frame_deframer.sv
dv/tb_air_data_frame_deframer.sv
